// ===== design/sorted_value_table_with_repeats_macros.svh =====
// ---------------------------------------------------------------------------
// Sorted value table assertion macros
// Shared concurrent assertion forms, clocked on clk_i; SVT_ASSERT is off in reset on rst_ni.
// ---------------------------------------------------------------------------
`ifndef SORTED_VALUE_TABLE_WITH_REPEATS_MACROS_SVH
`define SORTED_VALUE_TABLE_WITH_REPEATS_MACROS_SVH

// Check a property outside reset.
`define SVT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property at every edge, reset included.
`define SVT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== design/svt_pkg.sv =====
// ---------------------------------------------------------------------------
// Sorted value table package
// Widths, request and status codes, and controller/datapath bundles.
// ---------------------------------------------------------------------------
package svt_pkg;

  localparam int TABLE_DEPTH_DEF = 64;
  localparam int REPEAT_BITS_DEF = 16;

  localparam int VALUE_W   = 32;
  localparam int IDX_W     = 6;
  localparam int USED_W    = 7;
  localparam int TOTAL_W   = 32;
  localparam int REP_OUT_W = 16;
  localparam int REQ_W     = 2;
  localparam int STATUS_W  = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_READ   = 2'd1,
    REQ_CLEAR  = 2'd2
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_NEW   = 2'd0,
    ST_DUP   = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  // Controller to datapath
  typedef struct packed {
    logic    capture;
    logic    total_inc;
    logic    count_clr;
    logic    mem_rd;
    logic    rd_sel_idx;
    logic    ptr_load_top;
    logic    ptr_dec;
    logic    pos_next;
    logic    pos_zero;
    logic    rep_inc;
    logic    shift_wr;
    logic    place;
    logic    set_status;
    status_e status;
    logic    load_entry;
    logic    load_out;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             used_zero;
    logic             full;
    logic             idx_ok;
    logic             match;
    logic             greater;
    logic             ptr_zero;
    logic             ptr_top;
    logic             ptr_at_pos;
    logic             out_free;
  } sts_t;

endpackage

// ===== design/svt_ctrl.sv =====
// ---------------------------------------------------------------------------
// Sorted value table controller
// Sequences search, shift, place, read and result hand-off per request.
// ---------------------------------------------------------------------------
module svt_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  svt_pkg::sts_t sts_i,
  output svt_pkg::cmd_t cmd_o
);
  import svt_pkg::*;

  `include "sorted_value_table_with_repeats_macros.svh"

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_DEC      = 9'b000000010,
    S_SRCH_RD  = 9'b000000100,
    S_SRCH_CMP = 9'b000001000,
    S_SHFT_RD  = 9'b000010000,
    S_SHFT_WR  = 9'b000100000,
    S_PLACE    = 9'b001000000,
    S_RD_DATA  = 9'b010000000,
    S_OUT      = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.status = ST_NEW;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        unique case (sts_i.req)
          REQ_INSERT: begin
            cmd_o.total_inc = 1'b1;
            if (sts_i.used_zero) begin
              cmd_o.pos_zero = 1'b1;
              state_d = S_PLACE;
            end else begin
              cmd_o.ptr_load_top = 1'b1;
              state_d = S_SRCH_RD;
            end
          end
          REQ_READ: begin
            if (sts_i.idx_ok) begin
              cmd_o.mem_rd     = 1'b1;
              cmd_o.rd_sel_idx = 1'b1;
              state_d = S_RD_DATA;
            end else begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_EMPTY;
              state_d = S_OUT;
            end
          end
          REQ_CLEAR: begin
            cmd_o.count_clr  = 1'b1;
            cmd_o.set_status = 1'b1;
            state_d = S_OUT;
          end
          default: begin
            cmd_o.set_status = 1'b1;
            state_d = S_OUT;
          end
        endcase
      end
      S_SRCH_RD: begin
        cmd_o.mem_rd = 1'b1;
        state_d = S_SRCH_CMP;
      end
      S_SRCH_CMP: begin
        if (sts_i.match) begin
          cmd_o.rep_inc    = 1'b1;
          cmd_o.set_status = 1'b1;
          cmd_o.status     = ST_DUP;
          state_d = S_OUT;
        end else if (sts_i.greater && !sts_i.ptr_zero) begin
          cmd_o.ptr_dec = 1'b1;
          state_d = S_SRCH_RD;
        end else if (sts_i.full) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = ST_FULL;
          state_d = S_OUT;
        end else if (sts_i.greater) begin
          cmd_o.pos_zero     = 1'b1;
          cmd_o.ptr_load_top = 1'b1;
          state_d = S_SHFT_RD;
        end else if (sts_i.ptr_top) begin
          cmd_o.pos_next = 1'b1;
          state_d = S_PLACE;
        end else begin
          cmd_o.pos_next     = 1'b1;
          cmd_o.ptr_load_top = 1'b1;
          state_d = S_SHFT_RD;
        end
      end
      S_SHFT_RD: begin
        cmd_o.mem_rd = 1'b1;
        state_d = S_SHFT_WR;
      end
      S_SHFT_WR: begin
        cmd_o.shift_wr = 1'b1;
        if (sts_i.ptr_at_pos) begin
          state_d = S_PLACE;
        end else begin
          cmd_o.ptr_dec = 1'b1;
          state_d = S_SHFT_RD;
        end
      end
      S_PLACE: begin
        cmd_o.place      = 1'b1;
        cmd_o.set_status = 1'b1;
        state_d = S_OUT;
      end
      S_RD_DATA: begin
        cmd_o.load_entry = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `SVT_ASSERT(a_load_needs_slot, cmd_o.load_out |-> sts_i.out_free, "result loaded into busy slot")
  `SVT_ASSERT(a_place_not_full, cmd_o.place |-> !sts_i.full, "value placed into full table")

endmodule

// ===== design/svt_datapath.sv =====
// ---------------------------------------------------------------------------
// Sorted value table datapath
// Value and repeat memories, pointers, counters and the result register.
// ---------------------------------------------------------------------------
module svt_datapath #(
  parameter int TABLE_DEPTH = svt_pkg::TABLE_DEPTH_DEF,
  parameter int REPEAT_BITS = svt_pkg::REPEAT_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  svt_pkg::cmd_t                       cmd_i,
  output svt_pkg::sts_t                       sts_o,
  input  logic [svt_pkg::REQ_W-1:0]           req_type_i,
  input  logic signed [svt_pkg::VALUE_W-1:0]  value_in_i,
  input  logic [svt_pkg::IDX_W-1:0]           read_index_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [svt_pkg::STATUS_W-1:0]        status_o,
  output logic [svt_pkg::USED_W-1:0]          entries_used_o,
  output logic [svt_pkg::TOTAL_W-1:0]         total_inserts_o,
  output logic signed [svt_pkg::VALUE_W-1:0]  lowest_value_o,
  output logic signed [svt_pkg::VALUE_W-1:0]  highest_value_o,
  output logic signed [svt_pkg::VALUE_W-1:0]  entry_value_o,
  output logic [svt_pkg::REP_OUT_W-1:0]       entry_repeats_o
);
  import svt_pkg::*;

  `include "sorted_value_table_with_repeats_macros.svh"

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int IW = (CW > IDX_W) ? CW : IDX_W;

  logic signed [VALUE_W-1:0] val_mem [TABLE_DEPTH];
  logic [REPEAT_BITS-1:0]    rep_mem [TABLE_DEPTH];

  logic [REQ_W-1:0]          req_q;
  logic signed [VALUE_W-1:0] val_q;
  logic [IDX_W-1:0]          idx_q;
  logic [AW-1:0]             ptr_q, pos_q;
  logic [CW-1:0]             used_q;
  logic [TOTAL_W-1:0]        total_q;
  logic signed [VALUE_W-1:0] low_q, high_q;
  logic signed [VALUE_W-1:0] rd_val_q;
  logic [REPEAT_BITS-1:0]    rd_rep_q;
  status_e                   pend_status_q;
  logic signed [VALUE_W-1:0] pend_ev_q;
  logic [REP_OUT_W-1:0]      pend_er_q;
  logic                      out_valid_q;

  logic [AW-1:0]             rd_addr;
  logic [AW-1:0]             wr_addr;
  logic                      val_we, rep_we;
  logic signed [VALUE_W-1:0] val_wdata;
  logic [REPEAT_BITS-1:0]    rep_wdata;
  logic [REPEAT_BITS-1:0]    rep_bumped;
  logic [AW-1:0]             ptr_plus1;
  logic [AW-1:0]             used_top;

  assign ptr_plus1  = ptr_q + AW'(1);
  assign used_top   = AW'(used_q - CW'(1));
  assign rep_bumped = (&rd_rep_q) ? rd_rep_q : rd_rep_q + REPEAT_BITS'(1);

  assign sts_o.req        = req_q;
  assign sts_o.used_zero  = (used_q == '0);
  assign sts_o.full       = (used_q == CW'(TABLE_DEPTH));
  assign sts_o.idx_ok     = (IW'(idx_q) < IW'(used_q));
  assign sts_o.match      = (rd_val_q == val_q);
  assign sts_o.greater    = (rd_val_q > val_q);
  assign sts_o.ptr_zero   = (ptr_q == '0);
  assign sts_o.ptr_top    = (ptr_q == used_top);
  assign sts_o.ptr_at_pos = (ptr_q == pos_q);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  // Write port: shift up, place, or bump a repeat count
  always_comb begin
    val_we    = cmd_i.shift_wr || cmd_i.place;
    rep_we    = cmd_i.shift_wr || cmd_i.place || cmd_i.rep_inc;
    wr_addr   = ptr_q;
    val_wdata = rd_val_q;
    rep_wdata = rep_bumped;
    if (cmd_i.shift_wr) begin
      wr_addr   = ptr_plus1;
      rep_wdata = rd_rep_q;
    end else if (cmd_i.place) begin
      wr_addr   = pos_q;
      val_wdata = val_q;
      rep_wdata = '0;
    end
  end

  assign rd_addr = cmd_i.rd_sel_idx ? AW'(idx_q) : ptr_q;

  always_ff @(posedge clk_i) begin
    if (val_we) begin
      val_mem[wr_addr] <= val_wdata;
    end
    if (rep_we) begin
      rep_mem[wr_addr] <= rep_wdata;
    end
    if (cmd_i.mem_rd) begin
      rd_val_q <= val_mem[rd_addr];
      rd_rep_q <= rep_mem[rd_addr];
    end
  end

  // Request capture, pointers, extremes, pending result and result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= req_type_i;
      val_q <= value_in_i;
      idx_q <= read_index_i;
    end
    if (cmd_i.ptr_load_top) begin
      ptr_q <= used_top;
    end else if (cmd_i.ptr_dec) begin
      ptr_q <= ptr_q - AW'(1);
    end
    if (cmd_i.pos_zero) begin
      pos_q <= '0;
    end else if (cmd_i.pos_next) begin
      pos_q <= ptr_plus1;
    end
    if (cmd_i.place) begin
      if (used_q == '0) begin
        low_q  <= val_q;
        high_q <= val_q;
      end else begin
        if (pos_q == '0) begin
          low_q <= val_q;
        end
        if (pos_q == AW'(used_q)) begin
          high_q <= val_q;
        end
      end
    end
    if (cmd_i.set_status) begin
      pend_status_q <= cmd_i.status;
      pend_ev_q     <= '0;
      pend_er_q     <= '0;
    end else if (cmd_i.load_entry) begin
      pend_status_q <= ST_NEW;
      pend_ev_q     <= rd_val_q;
      pend_er_q     <= REP_OUT_W'(rd_rep_q);
    end
    if (cmd_i.load_out) begin
      status_o        <= pend_status_q;
      entries_used_o  <= USED_W'(used_q);
      total_inserts_o <= total_q;
      lowest_value_o  <= (used_q == '0) ? '0 : low_q;
      highest_value_o <= (used_q == '0) ? '0 : high_q;
      entry_value_o   <= pend_ev_q;
      entry_repeats_o <= pend_er_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.count_clr) begin
        used_q  <= '0;
        total_q <= '0;
      end else begin
        if (cmd_i.place) begin
          used_q <= used_q + CW'(1);
        end
        if (cmd_i.total_inc && (total_q != '1)) begin
          total_q <= total_q + TOTAL_W'(1);
        end
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

  `SVT_ASSERT_ALWAYS(a_used_bound, used_q <= CW'(TABLE_DEPTH), "entry count beyond depth")
  `SVT_ASSERT(a_used_step, (used_q != $past(used_q)) |-> ((used_q == $past(used_q) + CW'(1)) || (used_q == '0)), "entry count moved by more than one")
  `SVT_ASSERT(a_low_high, !sts_o.used_zero |-> (low_q <= high_q), "lowest above highest")

endmodule

// ===== design/sorted_value_table_with_repeats.sv =====
// ---------------------------------------------------------------------------
// Sorted value table with repeats
// Ascending table of distinct signed values with saturating repeat counts.
// ---------------------------------------------------------------------------
//
//  Channel | Direction | Beat fields
//  --------+-----------+--------------------------------------------------
//  in      | input     | req_type, value_in, read_index
//  out     | output    | status, entries_used, total_inserts, lowest_value,
//          |           | highest_value, entry_value, entry_repeats
//
//  One request is in work at a time; every request gives one result beat.
//  An insert searches the value memory downward from the top entry, then
//  shifts the larger entries one slot up, each step a read and a compare or
//  write; an insert into an empty table skips both. A repeat ends the search
//  at its matching entry.
//  Reset clears the entry and insert counts and the result valid flag; the memories need no pass.
//  A stalled result waits in the output register while the next beat is taken.
//
module sorted_value_table_with_repeats #(
  parameter int TABLE_DEPTH = svt_pkg::TABLE_DEPTH_DEF,
  parameter int REPEAT_BITS = svt_pkg::REPEAT_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [svt_pkg::REQ_W-1:0]           req_type_i,
  input  logic signed [svt_pkg::VALUE_W-1:0]  value_in_i,
  input  logic [svt_pkg::IDX_W-1:0]           read_index_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [svt_pkg::STATUS_W-1:0]        status_o,
  output logic [svt_pkg::USED_W-1:0]          entries_used_o,
  output logic [svt_pkg::TOTAL_W-1:0]         total_inserts_o,
  output logic signed [svt_pkg::VALUE_W-1:0]  lowest_value_o,
  output logic signed [svt_pkg::VALUE_W-1:0]  highest_value_o,
  output logic signed [svt_pkg::VALUE_W-1:0]  entry_value_o,
  output logic [svt_pkg::REP_OUT_W-1:0]       entry_repeats_o
);
  import svt_pkg::*;

  // Commands down to the datapath, flags back up to the controller
  cmd_t cmd;
  sts_t sts;

  // Sequence each request: decode, search, shift, place, hand off
  svt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Hold the memories, counters and the result register
  svt_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .REPEAT_BITS (REPEAT_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .req_type_i      (req_type_i),
    .value_in_i      (value_in_i),
    .read_index_i    (read_index_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .entries_used_o  (entries_used_o),
    .total_inserts_o (total_inserts_o),
    .lowest_value_o  (lowest_value_o),
    .highest_value_o (highest_value_o),
    .entry_value_o   (entry_value_o),
    .entry_repeats_o (entry_repeats_o)
  );

endmodule

// ===== tb/sorted_value_table_with_repeats_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sorted value table with repeats - regression bench
// Drives insert, read, clear and unknown request beats through the valid/ready
// input channel. It predicts every result beat from its own copy of the
// table, and compares each result beat field by field. A directed table comes
// first, then random episodes that fill, overflow and clear the table, then a
// final run with no idling that piles repeats onto one value back to back.
// ---------------------------------------------------------------------------
module sorted_value_table_with_repeats_tb;
  import svt_pkg::*;

  localparam int TABLE_DEPTH = TABLE_DEPTH_DEF;
  localparam int REPEAT_W    = REPEAT_BITS_DEF;

  // Request code that the block has no name for; it must still answer it.
  localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;

  localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

  localparam int RANDOM_ITEMS   = 1650;
  localparam int HOLD_OFF_AT    = 300;    // random beat that triggers the long stall
  localparam int HOLD_OFF_LEN   = 400;
  localparam int REPEAT_RUN     = 250;    // back-to-back inserts of one value
  localparam int DRAIN_CYCLES   = 300;    // beyond the worst insert latency
  localparam int LIMIT_CYCLES   = 4000000;
  localparam int NUM_DIRECTED   = 21;

  typedef struct packed {
    status_e                    status;
    logic [USED_W-1:0]          used;
    logic [TOTAL_W-1:0]         total;
    logic signed [VALUE_W-1:0]  lowest;
    logic signed [VALUE_W-1:0]  highest;
    logic signed [VALUE_W-1:0]  entry_val;
    logic [REP_OUT_W-1:0]       entry_reps;
  } table_result_t;

  typedef struct packed {
    logic [REQ_W-1:0]           req;
    logic signed [VALUE_W-1:0]  value;
    logic [IDX_W-1:0]           index;
    logic                       typed;
    table_result_t              result;
  } stim_row_t;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       in_valid_i;
  logic                       in_ready_o;
  logic [REQ_W-1:0]           req_type_i;
  logic signed [VALUE_W-1:0]  value_in_i;
  logic [IDX_W-1:0]           read_index_i;
  logic                       out_valid_o;
  logic                       out_ready_i;
  logic [STATUS_W-1:0]        status_o;
  logic [USED_W-1:0]          entries_used_o;
  logic [TOTAL_W-1:0]         total_inserts_o;
  logic signed [VALUE_W-1:0]  lowest_value_o;
  logic signed [VALUE_W-1:0]  highest_value_o;
  logic signed [VALUE_W-1:0]  entry_value_o;
  logic [REP_OUT_W-1:0]       entry_repeats_o;

  // Typed-in expectation that travels with the beat, like a payload field.
  logic                       beat_typed;
  table_result_t              beat_result;

  // Shadow of the table: values in ascending order, repeats alongside.
  logic signed [VALUE_W-1:0]  shadow_vals [TABLE_DEPTH];
  logic [REPEAT_W-1:0]        shadow_reps [TABLE_DEPTH];
  int                         shadow_used = 0;
  logic [TOTAL_W-1:0]         shadow_inserts = '0;

  table_result_t              pending_results [$];
  int                         mismatch_count = 0;
  int                         cycle_count = 0;
  bit                         quiet;          // no idling on either side
  bit                         hold_off_req;
  bit                         hold_off_done = 1'b0;

  // Directed table. Rows with typed set carry an expectation read straight
  // off the table contents; the rest are checked against the shadow.
  stim_row_t directed_rows [NUM_DIRECTED] = '{
    // read of an empty table after reset
    '{REQ_READ,   32'sd0,  6'd0,  1'b1, '{ST_EMPTY, 7'd0, 32'd0, 32'sd0, 32'sd0, 32'sd0, 16'd0}},
    '{REQ_INSERT, 32'sd0,  6'd0,  1'b1, '{ST_NEW,   7'd1, 32'd1, 32'sd0, 32'sd0, 32'sd0, 16'd0}},
    '{REQ_INSERT, VAL_MIN, 6'd0,  1'b1, '{ST_NEW,   7'd2, 32'd2, VAL_MIN, 32'sd0, 32'sd0, 16'd0}},
    '{REQ_INSERT, VAL_MAX, 6'd0,  1'b1, '{ST_NEW,   7'd3, 32'd3, VAL_MIN, VAL_MAX, 32'sd0, 16'd0}},
    // repeat of the middle entry, then read it back
    '{REQ_INSERT, 32'sd0,  6'd0,  1'b1, '{ST_DUP,   7'd3, 32'd4, VAL_MIN, VAL_MAX, 32'sd0, 16'd0}},
    '{REQ_READ,   32'sd0,  6'd1,  1'b1, '{ST_NEW,   7'd3, 32'd4, VAL_MIN, VAL_MAX, 32'sd0, 16'd1}},
    '{REQ_INSERT, VAL_MIN, 6'd0,  1'b1, '{ST_DUP,   7'd3, 32'd5, VAL_MIN, VAL_MAX, 32'sd0, 16'd0}},
    '{REQ_INSERT, -32'sd1, 6'd0,  1'b0, '0},
    '{REQ_INSERT, 32'sd1,  6'd0,  1'b0, '0},
    '{REQ_INSERT, VAL_MAX, 6'd0,  1'b0, '0},
    '{REQ_READ,   32'sd0,  6'd0,  1'b0, '0},
    '{REQ_READ,   32'sd0,  6'd4,  1'b0, '0},
    // reads past the end of the table, the last one at the top index
    '{REQ_READ,   32'sd0,  6'd5,  1'b1, '{ST_EMPTY, 7'd5, 32'd8, VAL_MIN, VAL_MAX, 32'sd0, 16'd0}},
    '{REQ_READ,   VAL_MAX, 6'd63, 1'b1, '{ST_EMPTY, 7'd5, 32'd8, VAL_MIN, VAL_MAX, 32'sd0, 16'd0}},
    // unknown request leaves the table alone
    '{REQ_UNKNOWN, 32'sh1234_5678, 6'h2A, 1'b1,
      '{ST_NEW, 7'd5, 32'd8, VAL_MIN, VAL_MAX, 32'sd0, 16'd0}},
    '{REQ_CLEAR,  VAL_MIN, 6'd63, 1'b1, '{ST_NEW,   7'd0, 32'd0, 32'sd0, 32'sd0, 32'sd0, 16'd0}},
    '{REQ_READ,   32'sd0,  6'd0,  1'b1, '{ST_EMPTY, 7'd0, 32'd0, 32'sd0, 32'sd0, 32'sd0, 16'd0}},
    '{REQ_INSERT, -32'sd5, 6'd0,  1'b1, '{ST_NEW,   7'd1, 32'd1, -32'sd5, -32'sd5, 32'sd0, 16'd0}},
    '{REQ_READ,   32'sd0,  6'd0,  1'b1, '{ST_NEW,   7'd1, 32'd1, -32'sd5, -32'sd5, -32'sd5, 16'd0}},
    // new lowest value shifts the table up
    '{REQ_INSERT, -32'sd6, 6'd0,  1'b0, '0},
    '{REQ_READ,   32'sd0,  6'd1,  1'b0, '0}
  };

  // Values that sit on the signed range limits and around zero.
  localparam logic signed [VALUE_W-1:0] CORNER_VALUES [5] =
    '{VAL_MIN, VAL_MAX, 32'sd0, -32'sd1, 32'sd1};

  sorted_value_table_with_repeats uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .req_type_i      (req_type_i),
    .value_in_i      (value_in_i),
    .read_index_i    (read_index_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .entries_used_o  (entries_used_o),
    .total_inserts_o (total_inserts_o),
    .lowest_value_o  (lowest_value_o),
    .highest_value_o (highest_value_o),
    .entry_value_o   (entry_value_o),
    .entry_repeats_o (entry_repeats_o)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // -------------------------------------------------------------------------
  // Shadow table: apply one accepted request and return the result it gives.
  // -------------------------------------------------------------------------
  function automatic table_result_t apply_request(input logic [REQ_W-1:0] req,
                                                  input logic signed [VALUE_W-1:0] val,
                                                  input logic [IDX_W-1:0] idx);
    table_result_t res;
    int            pos;

    res = '0;
    res.status = ST_NEW;
    case (req)
      REQ_INSERT: begin
        // Count every insert, dropped ones included; stop at all ones.
        if (shadow_inserts != '1) shadow_inserts++;
        pos = 0;
        while (pos < shadow_used && shadow_vals[pos] < val) pos++;
        if (pos < shadow_used && shadow_vals[pos] == val) begin
          if (shadow_reps[pos] != '1) shadow_reps[pos]++;
          res.status = ST_DUP;
        end else if (shadow_used >= TABLE_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          // Open a slot at pos by moving the larger entries up by one.
          for (int i = shadow_used; i > pos; i--) begin
            shadow_vals[i] = shadow_vals[i-1];
            shadow_reps[i] = shadow_reps[i-1];
          end
          shadow_vals[pos] = val;
          shadow_reps[pos] = '0;
          shadow_used++;
        end
      end
      REQ_READ: begin
        if (int'(idx) < shadow_used) begin
          res.entry_val  = shadow_vals[idx];
          res.entry_reps = REP_OUT_W'(shadow_reps[idx]);
        end else begin
          res.status = ST_EMPTY;
        end
      end
      REQ_CLEAR: begin
        shadow_used    = 0;
        shadow_inserts = '0;
      end
      default: ;  // unknown request: hold all state
    endcase
    res.used  = USED_W'(shadow_used);
    res.total = shadow_inserts;
    if (shadow_used != 0) begin
      res.lowest  = shadow_vals[0];
      res.highest = shadow_vals[shadow_used-1];
    end
    return res;
  endfunction

  task automatic check_result(input table_result_t exp, input table_result_t act);
    if (act.status !== exp.status) begin
      $error("status: expected %0d, got %0d", exp.status, act.status);
      mismatch_count++;
    end
    if (act.used !== exp.used) begin
      $error("entries_used: expected %0d, got %0d", exp.used, act.used);
      mismatch_count++;
    end
    if (act.total !== exp.total) begin
      $error("total_inserts: expected %0d, got %0d", exp.total, act.total);
      mismatch_count++;
    end
    if (act.lowest !== exp.lowest) begin
      $error("lowest_value: expected %0d, got %0d", exp.lowest, act.lowest);
      mismatch_count++;
    end
    if (act.highest !== exp.highest) begin
      $error("highest_value: expected %0d, got %0d", exp.highest, act.highest);
      mismatch_count++;
    end
    if (act.entry_val !== exp.entry_val) begin
      $error("entry_value: expected %0d, got %0d", exp.entry_val, act.entry_val);
      mismatch_count++;
    end
    if (act.entry_reps !== exp.entry_reps) begin
      $error("entry_repeats: expected %0d, got %0d", exp.entry_reps, act.entry_reps);
      mismatch_count++;
    end
  endtask

  // -------------------------------------------------------------------------
  // Offer one request beat and hold it until accepted. Call at a rising edge;
  // returns at the edge that accepted the beat, with valid still high so that
  // a following beat can go out back to back.
  // -------------------------------------------------------------------------
  task automatic send_request(input logic [REQ_W-1:0] req,
                              input logic signed [VALUE_W-1:0] val,
                              input logic [IDX_W-1:0] idx,
                              input logic typed,
                              input table_result_t result);
    // Idle the sender now and then, unless in the final quiet stretch.
    if (!quiet && $urandom_range(0, 99) < 20) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    req_type_i   <= req;
    value_in_i   <= val;
    read_index_i <= idx;
    beat_typed   <= typed;
    beat_result  <= result;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // -------------------------------------------------------------------------
  // Beat monitor: predict on every accepted request, check every result.
  // Both channels are sampled at the rising edge, before any update lands.
  // -------------------------------------------------------------------------
  always @(posedge clk_i) begin
    table_result_t predicted;
    table_result_t observed;

    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        // Advance the shadow even for typed rows so that later rows line up.
        predicted = apply_request(req_type_i, value_in_i, read_index_i);
        pending_results.insert(pending_results.size(), beat_typed ? beat_result : predicted);
      end
      if (out_valid_o && out_ready_i) begin
        if (pending_results.size() == 0) begin
          $error("result beat with no request outstanding");
          mismatch_count++;
        end else begin
          observed.status     = status_e'(status_o);
          observed.used       = entries_used_o;
          observed.total      = total_inserts_o;
          observed.lowest     = lowest_value_o;
          observed.highest    = highest_value_o;
          observed.entry_val  = entry_value_o;
          observed.entry_reps = entry_repeats_o;
          check_result(pending_results.pop_front(), observed);
        end
      end
    end
  end

  // Watchdog: drop the run if it hangs.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("sorted_value_table_with_repeats regression: fail");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // Result receiver: random stalls, runs of steady ready, and one long
  // hold-off that backs the block up until it stops taking requests.
  // -------------------------------------------------------------------------
  initial begin
    out_ready_i = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_off_req && !hold_off_done) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_OFF_LEN) @(posedge clk_i);
        hold_off_done = 1'b1;
      end else if (!quiet && $urandom_range(0, 99) < 25) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk_i);
      end
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus
  // -------------------------------------------------------------------------
  initial begin
    int                         item_count;
    int                         episode_left;
    int                         insert_share;
    int                         roll;
    int                         est_used;
    bit                         fill_episode;
    logic signed [VALUE_W-1:0]  val;
    logic [IDX_W-1:0]           idx;
    logic signed [VALUE_W-1:0]  value_pool [$];
    bit                         pooled [int];
    logic signed [VALUE_W-1:0]  rep_value;

    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    req_type_i     = REQ_INSERT;
    value_in_i     = '0;
    read_index_i   = '0;
    beat_typed     = 1'b0;
    beat_result    = '0;
    quiet          = 1'b0;
    hold_off_req   = 1'b0;
    episode_left   = 0;
    fill_episode   = 1'b0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table: extremes, every request kind, the edge cases.
    foreach (directed_rows[r]) begin
      send_request(directed_rows[r].req, directed_rows[r].value, directed_rows[r].index,
                   directed_rows[r].typed, directed_rows[r].result);
    end

    // Random episodes. Each opens with a clear; fill episodes are mostly fresh
    // inserts so that the table runs full and drops values, the others mix
    // reads, repeats and stray clears.
    item_count = 0;
    while (item_count < RANDOM_ITEMS) begin
      if (item_count == HOLD_OFF_AT) hold_off_req = 1'b1;
      if (episode_left == 0) begin
        fill_episode = ($urandom_range(0, 2) == 0);
        episode_left = fill_episode ? $urandom_range(120, 260) : $urandom_range(20, 200);
        value_pool.delete();
        pooled.delete();
        send_request(REQ_CLEAR, $urandom, IDX_W'($urandom), 1'b0, '0);
        item_count++;
        continue;
      end
      episode_left--;
      insert_share = fill_episode ? 80 : 55;
      est_used = (value_pool.size() > TABLE_DEPTH) ? TABLE_DEPTH : value_pool.size();
      roll = $urandom_range(0, 99);
      if (roll < insert_share) begin
        roll = $urandom_range(0, 99);
        if (value_pool.size() != 0 && roll < 30)
          val = value_pool[$urandom_range(0, value_pool.size() - 1)];
        else if (roll < 40)
          val = CORNER_VALUES[$urandom_range(0, 4)];
        else if (roll < 65)
          val = $signed($urandom_range(0, 400)) - 200;
        else
          val = $urandom;
        if (!pooled.exists(int'(val))) begin
          pooled[int'(val)] = 1'b1;
          value_pool.insert(value_pool.size(), val);
        end
        send_request(REQ_INSERT, val, IDX_W'($urandom), 1'b0, '0);
      end else if (roll < insert_share + (fill_episode ? 17 : 33)) begin
        if (est_used != 0 && $urandom_range(0, 99) < 70)
          idx = IDX_W'($urandom_range(0, est_used - 1));
        else
          idx = IDX_W'($urandom_range(0, 63));
        send_request(REQ_READ, $urandom, idx, 1'b0, '0);
      end else if (!fill_episode && roll < 96) begin
        // Stray clear mid-episode: drop the pool with it.
        value_pool.delete();
        pooled.delete();
        send_request(REQ_CLEAR, $urandom, IDX_W'($urandom), 1'b0, '0);
      end else begin
        send_request(REQ_UNKNOWN, $urandom, IDX_W'($urandom), 1'b0, '0);
      end
      item_count++;
    end

    // Final stretch, no idling: pile repeats onto one value back to back,
    // then read it back and insert once more.
    quiet = 1'b1;
    rep_value = $urandom;
    send_request(REQ_CLEAR, $urandom, IDX_W'($urandom), 1'b0, '0);
    repeat (REPEAT_RUN) send_request(REQ_INSERT, rep_value, IDX_W'($urandom), 1'b0, '0);
    send_request(REQ_READ, $urandom, 6'd0, 1'b0, '0);
    send_request(REQ_INSERT, rep_value, IDX_W'($urandom), 1'b0, '0);
    send_request(REQ_READ, $urandom, 6'd0, 1'b0, '0);
    send_request(REQ_READ, $urandom, 6'd1, 1'b0, '0);
    in_valid_i <= 1'b0;

    // Drain, then give any stray beat time to show up.
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("sorted_value_table_with_repeats regression: pass");
    end else begin
      $display("sorted_value_table_with_repeats regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/svt_pkg.sv
design/svt_ctrl.sv
design/svt_datapath.sv
design/sorted_value_table_with_repeats.sv
tb/sorted_value_table_with_repeats_tb.sv
